@@ hdl/bms_pkg.sv @@
// Shared types and constants for the message segmenter.
// No dependencies; imported by every module of the block.
package bms_pkg;

    localparam logic       K_CMD_START  = 1'b0;
    localparam logic       K_CMD_DATA   = 1'b1;
    localparam logic [7:0] K_START_FLAG = 8'h80;
    localparam logic [7:0] K_CONT_FLAG  = 8'hC0;
    localparam logic [10:0] K_ID_RESET  = 11'h6FD;
    localparam logic [3:0] K_HDR_LEN    = 4'd2;
    localparam logic [3:0] K_FULL_LEN   = 4'd8;
    localparam logic [11:0] K_SHORT_MAX = 12'd6;
    localparam logic [11:0] K_START_DATA = 12'd4;
    localparam logic [2:0] K_CONT_DATA  = 3'd7;

    typedef struct packed {
        logic [10:0]     frame_id;
        logic [3:0]      frame_len;
        logic [7:0][7:0] bytes;
        logic            last_frame;
    } t_frame;

endpackage

@@ hdl/bms_seg_core.sv @@
// Message state and frame assembly for the segmenter.
// Depends on bms_pkg; feeds the result register in bms_out_stage.
module bms_seg_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_take,
    input  logic            i_cmd,
    input  logic [2:0]      i_opcode,
    input  logic [5:0]      i_unit_id,
    input  logic [5:0]      i_function_id,
    input  logic [11:0]     i_msg_len,
    input  logic [7:0]      i_data_byte,
    input  logic [10:0]     i_frame_id,
    output logic            o_emit,
    output bms_pkg::t_frame o_frame
);
    import bms_pkg::*;

    logic        r_busy;
    logic [2:0]  r_opcode;
    logic [5:0]  r_unit;
    logic [5:0]  r_function;
    logic [11:0] r_total;
    logic [11:0] r_taken;
    logic [7:0]  r_buf [0:6];
    logic [2:0]  r_fill;
    logic [3:0]  r_seq;

    logic        n_busy;
    logic [11:0] n_taken;
    logic [2:0]  n_fill;
    logic [3:0]  n_seq;

    logic [2:0]      idx;
    logic [2:0]      fill_inc;
    logic [7:0]      buf_next [0:6];
    logic [7:0]      h0;
    logic [7:0]      h1;
    logic [7:0][7:0] raw;
    logic [3:0]      len;
    logic            last;
    logic            emit;
    logic            take_data;

    assign take_data = i_take && (i_cmd == K_CMD_DATA) && r_busy;
    assign idx       = (r_fill == K_CONT_DATA) ? 3'd0 : r_fill;
    assign fill_inc  = idx + 3'd1;

    always_comb begin
        for (int i = 0; i < 7; i++) begin
            buf_next[i] = (3'(i) == idx) ? i_data_byte : r_buf[i];
        end
    end

    always_comb begin
        n_busy  = r_busy;
        n_taken = r_taken;
        n_fill  = r_fill;
        n_seq   = r_seq;
        emit    = 1'b0;
        last    = 1'b0;
        len     = K_HDR_LEN;
        raw     = '0;
        h0      = {1'b0, r_opcode, r_unit[5:2]};
        h1      = {r_unit[1:0], r_function};
        if (i_take && (i_cmd == K_CMD_START)) begin
            n_taken = '0;
            n_fill  = '0;
            n_seq   = '0;
            n_busy  = (i_msg_len != 12'd0);
            h0      = {1'b0, i_opcode, i_unit_id[5:2]};
            h1      = {i_unit_id[1:0], i_function_id};
            raw[0]  = h0;
            raw[1]  = h1;
            emit    = (i_msg_len == 12'd0);
            last    = 1'b1;
        end else if (take_data) begin
            n_taken = r_taken + 12'd1;
            n_fill  = fill_inc;
            if (r_total <= K_SHORT_MAX) begin
                raw[0] = h0;
                raw[1] = h1;
                for (int i = 0; i < 6; i++) begin
                    raw[i + 2] = buf_next[i];
                end
                len  = 4'(r_total[2:0]) + K_HDR_LEN;
                last = 1'b1;
                if (n_taken == r_total) begin
                    emit   = 1'b1;
                    n_busy = 1'b0;
                    n_fill = '0;
                end
            end else if (n_taken <= K_START_DATA) begin
                raw[0] = K_START_FLAG | {4'b0, r_total[11:8]};
                raw[1] = r_total[7:0];
                raw[2] = h0;
                raw[3] = h1;
                for (int i = 0; i < 4; i++) begin
                    raw[i + 4] = buf_next[i];
                end
                len = K_FULL_LEN;
                if (n_taken == K_START_DATA) begin
                    emit   = 1'b1;
                    n_fill = '0;
                end
            end else begin
                raw[0] = K_CONT_FLAG | {4'b0, r_seq};
                for (int i = 0; i < 7; i++) begin
                    raw[i + 1] = buf_next[i];
                end
                len  = {1'b0, fill_inc} + 4'd1;
                last = (n_taken == r_total);
                if ((fill_inc == K_CONT_DATA) || last) begin
                    emit   = 1'b1;
                    n_seq  = r_seq + 4'd1;
                    n_fill = '0;
                    if (last) begin
                        n_busy = 1'b0;
                    end
                end
            end
        end
    end

    always_comb begin
        o_frame.frame_id   = i_frame_id;
        o_frame.frame_len  = len;
        o_frame.last_frame = last;
        for (int i = 0; i < 8; i++) begin
            o_frame.bytes[i] = (4'(i) < len) ? raw[i] : 8'd0;
        end
    end

    assign o_emit = emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_taken <= '0;
            r_fill  <= '0;
            r_seq   <= '0;
            r_total <= '0;
        end else begin
            r_busy  <= n_busy;
            r_taken <= n_taken;
            r_fill  <= n_fill;
            r_seq   <= n_seq;
            if (i_take && (i_cmd == K_CMD_START)) begin
                r_total <= i_msg_len;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take && (i_cmd == K_CMD_START)) begin
            r_opcode   <= i_opcode;
            r_unit     <= i_unit_id;
            r_function <= i_function_id;
        end
        if (take_data) begin
            r_buf[idx] <= i_data_byte;
        end
    end

`ifndef SYNTHESIS
    a_idle_empty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> (r_fill == 3'd0))
        else $error("fill count nonzero with no message open");
    a_fill_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill != K_CONT_DATA)
        else $error("fill count reached a full continuation without emitting");
    a_taken_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_taken < r_total))
        else $error("open message already has all its bytes");
    a_len_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_emit |-> ((o_frame.frame_len >= K_HDR_LEN) && (o_frame.frame_len <= K_FULL_LEN)))
        else $error("emitted frame length out of range");
`endif

endmodule

@@ hdl/bms_out_stage.sv @@
// Result register between frame assembly and the output channel.
// Depends on bms_pkg for the frame type.
module bms_out_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_load,
    input  bms_pkg::t_frame i_frame,
    input  logic            i_out_ready,
    output logic            o_space,
    output logic            o_out_valid,
    output bms_pkg::t_frame o_frame
);
    import bms_pkg::*;

    logic   r_valid;
    t_frame r_frame;

    assign o_space     = !r_valid || i_out_ready;
    assign o_out_valid = r_valid;
    assign o_frame     = r_frame;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_space) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_space && i_load) begin
            r_frame <= i_frame;
        end
    end

endmodule

@@ hdl/bap_message_segmenter_unit.sv @@
// Top level of the message segmenter: configuration register, assembly core,
// result register. Depends on bms_pkg, bms_seg_core and bms_out_stage.
//
// Takes one start or data beat per cycle unless stalled and emits a CAN frame
// in the cycle after the beat that completes it. Input ready falls only while
// a finished frame is held in the result register and the output side is not
// ready; the result register is the only stage between the two channels.
// Configuration beats are always accepted and take effect on the next frame.
module bap_message_segmenter_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [10:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_cmd,
    input  logic [2:0]  i_opcode,
    input  logic [5:0]  i_unit_id,
    input  logic [5:0]  i_function_id,
    input  logic [11:0] i_msg_len,
    input  logic [7:0]  i_data_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [10:0] o_frame_id,
    output logic [3:0]  o_frame_len,
    output logic [7:0]  o_byte0,
    output logic [7:0]  o_byte1,
    output logic [7:0]  o_byte2,
    output logic [7:0]  o_byte3,
    output logic [7:0]  o_byte4,
    output logic [7:0]  o_byte5,
    output logic [7:0]  o_byte6,
    output logic [7:0]  o_byte7,
    output logic        o_last_frame
);
    import bms_pkg::*;

    logic [10:0] r_frame_id;
    logic        take;
    logic        emit;
    logic        space;
    t_frame      core_frame;
    t_frame      out_frame;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = space;
    assign take        = i_in_valid && space;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_id <= K_ID_RESET;
        end else if (i_cfg_valid) begin
            r_frame_id <= i_cfg_data;
        end
    end

    bms_seg_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_take        (take),
        .i_cmd         (i_cmd),
        .i_opcode      (i_opcode),
        .i_unit_id     (i_unit_id),
        .i_function_id (i_function_id),
        .i_msg_len     (i_msg_len),
        .i_data_byte   (i_data_byte),
        .i_frame_id    (r_frame_id),
        .o_emit        (emit),
        .o_frame       (core_frame)
    );

    bms_out_stage u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (emit),
        .i_frame     (core_frame),
        .i_out_ready (i_out_ready),
        .o_space     (space),
        .o_out_valid (o_out_valid),
        .o_frame     (out_frame)
    );

    assign o_frame_id   = out_frame.frame_id;
    assign o_frame_len  = out_frame.frame_len;
    assign o_byte0      = out_frame.bytes[0];
    assign o_byte1      = out_frame.bytes[1];
    assign o_byte2      = out_frame.bytes[2];
    assign o_byte3      = out_frame.bytes[3];
    assign o_byte4      = out_frame.bytes[4];
    assign o_byte5      = out_frame.bytes[5];
    assign o_byte6      = out_frame.bytes[6];
    assign o_byte7      = out_frame.bytes[7];
    assign o_last_frame = out_frame.last_frame;

endmodule
